/* rtl/core/cashaddr_pkg.sv */
// shared types, constants and functions of the cashaddr streamer
// polymod fold step, base32 alphabet lookup, queue entry layout
// no dependencies
`default_nettype none

package cashaddr_pkg;

  localparam logic [1:0] CMD_PREFIX  = 2'd0;
  localparam logic [1:0] CMD_SEP     = 2'd1;
  localparam logic [1:0] CMD_PAYLOAD = 2'd2;

  localparam logic [7:0] CHAR_COLON = 8'h3a;

  localparam int CASH_QDEPTH = 2;

  localparam logic [39:0] GEN0 = 40'h98f2bc8e61;
  localparam logic [39:0] GEN1 = 40'h79b76d99e2;
  localparam logic [39:0] GEN2 = 40'hf33e5fb3c4;
  localparam logic [39:0] GEN3 = 40'hae2eabe2a8;
  localparam logic [39:0] GEN4 = 40'h1e4f43e470;
  localparam logic [39:0] CHK_INIT = 40'd1;

  localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef struct packed {
    logic [1:0]      n_slot;
    logic [2:0][4:0] fsym;
    logic [2:0][7:0] ch;
    logic            fin;
  } entry_t;

  function automatic logic [39:0] polymod_fold(input logic [39:0] c, input logic [4:0] sym);
    logic [4:0]  top;
    logic [39:0] r;
    top = c[39:35];
    r   = {c[34:0], sym};
    if (top[0]) r = r ^ GEN0;
    if (top[1]) r = r ^ GEN1;
    if (top[2]) r = r ^ GEN2;
    if (top[3]) r = r ^ GEN3;
    if (top[4]) r = r ^ GEN4;
    return r;
  endfunction

  function automatic logic [7:0] b32_char(input logic [4:0] sym);
    logic [255:0] t;
    t = ALPHABET >> {(5'd31 - sym), 3'b000};
    return t[7:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cashaddr_front.sv */
// front end: accepts input words, regroups payload bytes into 5-bit symbols
// and pushes one entry per prefix, separator or payload word into the queue; uses cashaddr_pkg
`default_nettype none

module cashaddr_front
  import cashaddr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_is_final,
  output logic            q_valid,
  input  wire logic       q_ready,
  output entry_t          q_entry
);

  logic [3:0]  pend_r, pend_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [11:0] w, t0, t1, t2;
  logic [3:0]  tot, sh0, rem;
  logic [4:0]  s0, s1, psym;
  logic        two, pad, acc;

  assign in_ready = q_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    w    = {pend_r, in_data_byte};
    tot  = {1'b0, cnt_r} + 4'd8;
    sh0  = tot - 4'd5;
    t0   = w >> sh0;
    s0   = t0[4:0];
    two  = (sh0 >= 4'd5);
    t1   = w >> (sh0 - 4'd5);
    s1   = t1[4:0];
    rem  = two ? (sh0 - 4'd5) : sh0;
    pad  = in_is_final && (rem != 4'd0);
    t2   = w << (4'd5 - rem);
    psym = t2[4:0];

    q_entry = '0;
    q_valid = 1'b0;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    case (in_cmd)
      CMD_PREFIX: begin
        q_valid         = in_valid;
        q_entry.n_slot  = 2'd1;
        q_entry.fsym[0] = in_data_byte[4:0];
        q_entry.ch[0]   = in_data_byte;
      end
      CMD_SEP: begin
        q_valid         = in_valid;
        q_entry.n_slot  = 2'd1;
        q_entry.fsym[0] = 5'd0;
        q_entry.ch[0]   = CHAR_COLON;
      end
      CMD_PAYLOAD: begin
        q_valid         = in_valid;
        q_entry.n_slot  = 2'd1 + {1'b0, two} + {1'b0, pad};
        q_entry.fsym[0] = s0;
        q_entry.fsym[1] = two ? s1 : psym;
        q_entry.fsym[2] = psym;
        q_entry.ch[0]   = b32_char(s0);
        q_entry.ch[1]   = b32_char(two ? s1 : psym);
        q_entry.ch[2]   = b32_char(psym);
        q_entry.fin     = in_is_final;
        pend_nxt        = w[3:0];
        cnt_nxt         = in_is_final ? 3'd0 : rem[2:0];
      end
      default: begin
        q_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else if (acc) begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cashaddr_queue.sv */
// short fifo of symbol entries between front and back end
// uses cashaddr_pkg for the entry layout
`default_nettype none

module cashaddr_queue
  import cashaddr_pkg::*;
#(
  parameter int DEPTH = CASH_QDEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire entry_t wr_entry,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output entry_t    rd_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [AW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   count_r;
  logic            push, pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_entry = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (pop)  rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cashaddr_back.sv */
// back end: folds symbols into the polymod, emits one character a cycle while it has
// one and out_ready does not stall, runs the zero folds and checksum characters; uses cashaddr_pkg
`default_nettype none

module cashaddr_back
  import cashaddr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  output logic            q_ready,
  input  wire entry_t     q_entry,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char_out,
  output logic            out_is_check,
  output logic            out_end_of_run
);

  typedef enum logic [2:0] {
    ST_SLOT  = 3'b001,
    ST_ZERO  = 3'b010,
    ST_CHECK = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic [39:0] chk_r, chk_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic        ic_r, ic_nxt;
  logic        eor_r, eor_nxt;
  logic        can_emit, last_slot;

  assign can_emit       = !ov_r || out_ready;
  assign last_slot      = (idx_r == (q_entry.n_slot - 2'd1));
  assign out_valid      = ov_r;
  assign out_char_out   = ch_r;
  assign out_is_check   = ic_r;
  assign out_end_of_run = eor_r;

  always_comb begin
    state_nxt = state_r;
    chk_nxt   = chk_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    ch_nxt    = ch_r;
    ic_nxt    = ic_r;
    eor_nxt   = eor_r;
    q_ready   = 1'b0;
    case (state_r)
      ST_SLOT: begin
        if (q_valid && can_emit) begin
          chk_nxt = polymod_fold(chk_r, q_entry.fsym[idx_r]);
          ov_nxt  = 1'b1;
          ch_nxt  = q_entry.ch[idx_r];
          ic_nxt  = 1'b0;
          eor_nxt = last_slot && !q_entry.fin;
          if (last_slot) begin
            q_ready = 1'b1;
            idx_nxt = '0;
            cnt_nxt = '0;
            if (q_entry.fin) state_nxt = ST_ZERO;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      ST_ZERO: begin
        chk_nxt = polymod_fold(chk_r, 5'd0);
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          chk_nxt   = polymod_fold(chk_r, 5'd0) ^ CHK_INIT;
          cnt_nxt   = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (can_emit) begin
          ov_nxt  = 1'b1;
          ch_nxt  = b32_char(chk_r[39:35]);
          ic_nxt  = 1'b1;
          eor_nxt = (cnt_r == 3'd7);
          chk_nxt = {chk_r[34:0], 5'd0};
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            chk_nxt   = CHK_INIT;
            cnt_nxt   = '0;
            state_nxt = ST_SLOT;
          end
        end
      end
      default: begin
        state_nxt = ST_SLOT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SLOT;
      chk_r   <= CHK_INIT;
      idx_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_r   <= chk_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r  <= ch_nxt;
    ic_r  <= ic_nxt;
    eor_r <= eor_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/cashaddr_base32_checksum_encoder.sv */
// top level of the cashaddr base32 streamer with 40-bit polymod checksum
// instantiates cashaddr_front, cashaddr_queue, cashaddr_back; uses cashaddr_pkg
//
//   channel | ports                                         | dir | word
//   in      | in_valid/in_ready, in_cmd, in_data_byte,      | in  | one command
//           | in_is_final                                   |     |
//   out     | out_valid/out_ready, out_char_out,            | out | one character
//           | out_is_check, out_end_of_run                  |     |
//
// at most one character leaves per cycle, none while out_ready stalls; a prefix
// or separator word gives one character, a payload byte one or two, each through
// the single fold-and-emit step of the back end
// a final byte adds up to one padding character, eight zero folds and eight
// checksum characters; the front keeps accepting words until the queue is full
// rst_n is synchronous, active low; no clearing pass
// a stalled out_ready holds the output register and backs up through the queue
`default_nettype none

module cashaddr_base32_checksum_encoder
  import cashaddr_pkg::*;
#(
  parameter int QUEUE_DEPTH = CASH_QDEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_is_final,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char_out,
  output logic            out_is_check,
  output logic            out_end_of_run
);

  logic   fq_valid, fq_ready, qb_valid, qb_ready;
  entry_t fq_entry, qb_entry;

  cashaddr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .in_is_final  (in_is_final),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_entry      (fq_entry)
  );

  cashaddr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_entry (fq_entry),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_entry (qb_entry)
  );

  cashaddr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (qb_valid),
    .q_ready        (qb_ready),
    .q_entry        (qb_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_out   (out_char_out),
    .out_is_check   (out_is_check),
    .out_end_of_run (out_end_of_run)
  );

endmodule

`default_nettype wire

/* rtl/core/cashaddr_checker.sv */
// port-level checks of the cashaddr streamer, bound to the top level
// no dependencies beyond the top level's ports
`default_nettype none

module cashaddr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char_out,
  input wire logic       out_is_check,
  input wire logic       out_end_of_run
);

  logic [2:0] ccnt_r;
  logic       in_chk_r;
  logic       oacc;

  assign oacc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r   <= '0;
      in_chk_r <= 1'b0;
    end else if (oacc && out_is_check) begin
      ccnt_r   <= ccnt_r + 3'd1;
      in_chk_r <= !out_end_of_run;
    end
  end

  // checksum run ends on its eighth word
  a_chk_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_check |-> (out_end_of_run == (ccnt_r == 3'd7)))
    else $error("checksum run length wrong");

  // nothing interleaves a checksum run
  a_chk_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_chk_r |-> out_is_check)
    else $error("checksum run interrupted");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_char_out) && $stable(out_is_check)
      && $stable(out_end_of_run))
    else $error("output word changed while stalled");

endmodule

bind cashaddr_base32_checksum_encoder cashaddr_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_char_out   (out_char_out),
  .out_is_check   (out_is_check),
  .out_end_of_run (out_end_of_run)
);

`default_nettype wire

/* tb/tb.sv */
// testbench for cashaddr_base32_checksum_encoder: directed words, then random addresses
// predicts characters with its own polymod and base32 model; uses cashaddr_pkg
`timescale 1ns / 1ps

module tb;
  import cashaddr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int N_DIR = 22;
  localparam int N_RAND = 120;

  localparam logic [4:0][39:0] POLY_GEN = {
    40'h1e4f43e470, 40'hae2eabe2a8, 40'hf33e5fb3c4, 40'h79b76d99e2, 40'h98f2bc8e61
  };
  localparam logic [0:31][7:0] B32_SET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef struct packed {
    logic [7:0] ch;
    logic       chk;
    logic       eor;
  } char_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       fin;
    logic       typed;
    logic [1:0] n_typed;
    logic [7:0] ch_typed;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_cmd;
  logic [7:0] in_data_byte;
  logic       in_is_final;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char_out;
  logic       out_is_check;
  logic       out_end_of_run;

  char_t exp_chars[$];
  char_t pred_chars [0:10];
  int    pred_n;
  row_t  dir_rows [0:N_DIR-1];

  logic [39:0] sum_reg;
  logic [11:0] acc;
  logic [3:0]  cnt;

  int mismatches;
  int rand_items;
  int burst_left;
  int stall_left;
  int rx_cyc;

  cashaddr_base32_checksum_encoder u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_data_byte  (in_data_byte),
    .in_is_final   (in_is_final),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_out  (out_char_out),
    .out_is_check  (out_is_check),
    .out_end_of_run(out_end_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [39:0] fold5(input logic [39:0] c, input logic [4:0] s);
    logic [39:0] r;
    int k;
    r = {c[34:0], s};
    for (k = 0; k < 5; k++) begin
      if (c[35+k]) r = r ^ POLY_GEN[k];
    end
    return r;
  endfunction

  function automatic row_t row(input logic [1:0] c, input logic [7:0] b, input logic f,
                               input logic t, input logic [1:0] n, input logic [7:0] ch);
    row_t r;
    r = '{c, b, f, t, n, ch};
    return r;
  endfunction

  task automatic emit(input logic [4:0] s, input logic chk);
    pred_chars[pred_n] = '{B32_SET[s], chk, 1'b0};
    pred_n++;
  endtask

  task automatic predict_chars(input logic [1:0] c, input logic [7:0] b, input logic f);
    logic [4:0]  s;
    logic [11:0] tmp;
    logic [39:0] m;
    int i;
    pred_n = 0;
    case (c)
      CMD_PREFIX: begin
        sum_reg = fold5(sum_reg, b[4:0]);
        pred_chars[0] = '{b, 1'b0, 1'b0};
        pred_n = 1;
      end
      CMD_SEP: begin
        sum_reg = fold5(sum_reg, 5'd0);
        pred_chars[0] = '{CHAR_COLON, 1'b0, 1'b0};
        pred_n = 1;
      end
      CMD_PAYLOAD: begin
        acc = {acc[3:0], b};
        cnt = cnt + 4'd8;
        while (cnt >= 4'd5) begin
          s = acc[cnt - 4'd5 +: 5];
          sum_reg = fold5(sum_reg, s);
          emit(s, 1'b0);
          cnt = cnt - 4'd5;
        end
        if (f) begin
          if (cnt != 4'd0) begin
            tmp = acc << (4'd5 - cnt);
            s = tmp[4:0];
            sum_reg = fold5(sum_reg, s);
            emit(s, 1'b0);
          end
          for (i = 0; i < 8; i++) sum_reg = fold5(sum_reg, 5'd0);
          m = sum_reg ^ 40'd1;
          for (i = 0; i < 8; i++) emit(m[5*(7-i) +: 5], 1'b1);
          sum_reg = 40'd1;
          acc = 12'd0;
          cnt = 4'd0;
        end
      end
      default: ;
    endcase
    if (pred_n > 0) pred_chars[pred_n-1].eor = 1'b1;
  endtask

  task automatic send_word(input logic [1:0] c, input logic [7:0] b, input logic f,
                           input logic t, input logic [1:0] n_t, input logic [7:0] ch_t);
    int i;
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_data_byte <= b;
    in_is_final  <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_chars(c, b, f);
    if (t) begin
      if (n_t != 2'd0) exp_chars.push_back('{ch_t, 1'b0, 1'b1});
    end else begin
      for (i = 0; i < pred_n; i++) exp_chars.push_back(pred_chars[i]);
    end
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_chars.size() != 0) @(posedge clk);
  endtask

  task automatic rnd(input logic [1:0] c, input logic [7:0] b, input logic f);
    pace();
    send_word(c, b, f, 1'b0, 2'd0, 8'h00);
    if (c != CMD_UNUSED) rand_items++;
  endtask

  always @(posedge clk) begin : rx
    char_t e;
    logic  rdy;
    int    mode;
    if (rst_n && out_valid && out_ready) begin
      if (exp_chars.size() == 0) begin
        $display("%0t: unexpected word, expected none, got char %h chk %b eor %b",
                 $time, out_char_out, out_is_check, out_end_of_run);
        mismatches++;
      end else begin
        e = exp_chars.pop_front();
        if (out_char_out !== e.ch) begin
          $display("%0t: char_out expected %h got %h", $time, e.ch, out_char_out);
          mismatches++;
        end
        if (out_is_check !== e.chk) begin
          $display("%0t: is_check expected %b got %b", $time, e.chk, out_is_check);
          mismatches++;
        end
        if (out_end_of_run !== e.eor) begin
          $display("%0t: end_of_run expected %b got %b", $time, e.eor, out_end_of_run);
          mismatches++;
        end
      end
    end
    rx_cyc++;
    mode = (rx_cyc / 256) % 4;
    rdy = 1'b1;
    if (stall_left > 0) begin
      rdy = 1'b0;
      stall_left--;
    end else begin
      case (mode)
        1: rdy = ($urandom_range(0, 1) == 1);
        2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 20);
        3: rdy = (rx_cyc % 3 != 0);
        default: ;
      endcase
    end
    out_ready <= rdy;
  end

  initial begin : stim
    int i;
    int j;
    int n;
    int kind;
    mismatches   = 0;
    rand_items   = 0;
    burst_left   = 0;
    stall_left   = 0;
    rx_cyc       = 0;
    sum_reg      = 40'd1;
    acc          = 12'd0;
    cnt          = 4'd0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_cmd       <= CMD_PREFIX;
    in_data_byte <= 8'h00;
    in_is_final  <= 1'b0;

    dir_rows[0]  = row(CMD_UNUSED,  8'hff, 1'b1, 1'b1, 2'd0, 8'h00);
    dir_rows[1]  = row(CMD_PREFIX,  "b",   1'b1, 1'b1, 2'd1, "b");
    dir_rows[2]  = row(CMD_PREFIX,  "c",   1'b0, 1'b1, 2'd1, "c");
    dir_rows[3]  = row(CMD_PREFIX,  "h",   1'b0, 1'b1, 2'd1, "h");
    dir_rows[4]  = row(CMD_PREFIX,  8'h00, 1'b0, 1'b1, 2'd1, 8'h00);
    dir_rows[5]  = row(CMD_PREFIX,  8'hff, 1'b0, 1'b1, 2'd1, 8'hff);
    dir_rows[6]  = row(CMD_SEP,     8'hff, 1'b1, 1'b1, 2'd1, CHAR_COLON);
    dir_rows[7]  = row(CMD_UNUSED,  8'h00, 1'b0, 1'b1, 2'd0, 8'h00);
    dir_rows[8]  = row(CMD_PAYLOAD, 8'h00, 1'b0, 1'b1, 2'd1, "q");
    dir_rows[9]  = row(CMD_PAYLOAD, 8'hff, 1'b0, 1'b0, 2'd0, 8'h00);
    dir_rows[10] = row(CMD_PREFIX,  "x",   1'b0, 1'b1, 2'd1, "x");
    dir_rows[11] = row(CMD_SEP,     8'h00, 1'b0, 1'b1, 2'd1, CHAR_COLON);
    dir_rows[12] = row(CMD_PAYLOAD, 8'h80, 1'b0, 1'b0, 2'd0, 8'h00);
    dir_rows[13] = row(CMD_PAYLOAD, 8'h7f, 1'b0, 1'b0, 2'd0, 8'h00);
    dir_rows[14] = row(CMD_PAYLOAD, 8'haa, 1'b1, 1'b0, 2'd0, 8'h00);
    dir_rows[15] = row(CMD_PAYLOAD, 8'h01, 1'b1, 1'b0, 2'd0, 8'h00);
    dir_rows[16] = row(CMD_PREFIX,  "q",   1'b0, 1'b1, 2'd1, "q");
    dir_rows[17] = row(CMD_SEP,     8'h55, 1'b0, 1'b1, 2'd1, CHAR_COLON);
    dir_rows[18] = row(CMD_PAYLOAD, 8'hff, 1'b0, 1'b0, 2'd0, 8'h00);
    dir_rows[19] = row(CMD_PAYLOAD, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00);
    dir_rows[20] = row(CMD_PAYLOAD, 8'h55, 1'b0, 1'b0, 2'd0, 8'h00);
    dir_rows[21] = row(CMD_PAYLOAD, 8'haa, 1'b1, 1'b0, 2'd0, 8'h00);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      pace();
      send_word(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].fin,
                dir_rows[i].typed, dir_rows[i].n_typed, dir_rows[i].ch_typed);
    end
    drain();

    while (rand_items < N_RAND) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        rnd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (kind == 1) begin
        n = $urandom_range(1, 3);
        for (j = 0; j < n; j++) rnd(CMD_PAYLOAD, 8'($urandom_range(0, 255)), 1'b0);
      end else begin
        n = $urandom_range(1, 5);
        for (j = 0; j < n; j++) begin
          rnd(CMD_PREFIX,
              ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(97, 122)),
              1'($urandom_range(0, 1)));
        end
        rnd(CMD_SEP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        n = ($urandom_range(0, 15) == 0) ? 21 : $urandom_range(1, 8);
        for (j = 0; j < n; j++) rnd(CMD_PAYLOAD, 8'($urandom_range(0, 255)), j == n - 1);
      end
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
